// File: rtl/chol_pkg.sv
// Shared types and constants for the Cholesky tile factor block.
// No dependencies; imported by every module of the block but chol_ram.
`default_nettype none
package chol_pkg;
    localparam int TILE_MAX = 8;
    localparam int IDX_W    = 3;
    localparam int ADDR_W   = 2 * IDX_W;
    localparam int DEPTH    = TILE_MAX * TILE_MAX;
    localparam int DATA_W   = 32;
    localparam int SIZE_W   = 4;

    typedef enum logic [1:0] {
        WR_ZERO,
        WR_LKK,
        WR_DIV
    } wr_src_t;

    typedef struct packed {
        logic                a_we;
        logic [ADDR_W-1:0]   a_waddr;
        logic [ADDR_W-1:0]   a_raddr;
        logic [ADDR_W-1:0]   l_raddr0;
        logic [ADDR_W-1:0]   l_raddr1;
        logic                l_we;
        logic [ADDR_W-1:0]   l_waddr;
        wr_src_t             wr_src;
        logic                acc_load;
        logic                mul_en;
        logic                acc_sub;
        logic                sqrt_start;
        logic                div_start;
        logic                fail_clear;
        logic                fail_set;
        logic [IDX_W-1:0]    fail_idx;
        logic                out_load;
        logic [IDX_W-1:0]    out_col;
        logic                out_upper;
        logic                out_last;
    } cmd_t;

    typedef struct packed {
        logic q_pos;
        logic sqrt_busy;
        logic div_busy;
    } stat_t;
endpackage
`default_nettype wire

// File: rtl/chol_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module chol_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// File: rtl/chol_dp.sv
// Datapath: tile stores, multiply-accumulate, bit-serial square root and divider,
// pivot fail flags and the output register. Depends on chol_pkg and chol_ram.
`default_nettype none
module chol_dp (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire chol_pkg::cmd_t                cmd,
    output chol_pkg::stat_t                    stat,
    input  wire logic signed [31:0]            a_value,
    output logic signed [31:0]                 l_value,
    output logic                               column_failed,
    output logic                               last_of_tile
);
    import chol_pkg::*;

    logic [DATA_W-1:0] a_rdata, l_rdata0, l_rdata1, l_wdata;

    logic signed [51:0] acc_reg;
    logic signed [63:0] prod_reg;
    logic signed [31:0] q_sat;
    logic signed [47:0] prod_rnd;

    logic [47:0] sq_x_reg;
    logic [26:0] sq_rem_reg;
    logic [23:0] sq_root_reg;
    logic [4:0]  sq_cnt_reg;
    logic        sq_busy_reg;
    logic [26:0] sq_rem_sh;
    logic [26:0] sq_trial;
    logic [31:0] lkk_new;
    logic [24:0] lkk_reg;

    logic [47:0] dv_n_reg;
    logic [25:0] dv_rem_reg;
    logic [47:0] dv_q_reg;
    logic        dv_neg_reg;
    logic [5:0]  dv_cnt_reg;
    logic        dv_busy_reg;
    logic [25:0] dv_rem_sh;
    logic [31:0] dv_mag;
    logic [31:0] dv_result;

    logic [TILE_MAX-1:0] fail_reg;

    chol_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_a_ram (
        .clk(clk), .we(cmd.a_we), .waddr(cmd.a_waddr), .wdata(a_value),
        .raddr(cmd.a_raddr), .rdata(a_rdata)
    );
    // Two copies of the factor so that both operands of a product read at once.
    chol_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_l_ram0 (
        .clk(clk), .we(cmd.l_we), .waddr(cmd.l_waddr), .wdata(l_wdata),
        .raddr(cmd.l_raddr0), .rdata(l_rdata0)
    );
    chol_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_l_ram1 (
        .clk(clk), .we(cmd.l_we), .waddr(cmd.l_waddr), .wdata(l_wdata),
        .raddr(cmd.l_raddr1), .rdata(l_rdata1)
    );

    always_comb
    begin
        prod_rnd = 48'((prod_reg + 64'sd32768) >>> 16);
        if (acc_reg > 52'sd2147483647)
            q_sat = 32'sh7fffffff;
        else if (acc_reg < -52'sd2147483648)
            q_sat = 32'sh80000000;
        else
            q_sat = acc_reg[31:0];

        sq_rem_sh = {sq_rem_reg[24:0], sq_x_reg[47:46]};
        sq_trial  = {1'b0, sq_root_reg, 2'b01};
        lkk_new   = {8'd0, sq_root_reg} + 32'(sq_rem_reg > {3'd0, sq_root_reg});

        dv_rem_sh = {dv_rem_reg[24:0], dv_n_reg[47]};
        dv_mag    = q_sat[31] ? 32'(-q_sat) : 32'(q_sat);
        if (!dv_neg_reg)
            dv_result = (dv_q_reg > 48'h7fffffff) ? 32'h7fffffff : dv_q_reg[31:0];
        else
            dv_result = (dv_q_reg > 48'h80000000) ? 32'h80000000 : 32'(-dv_q_reg[31:0]);

        case (cmd.wr_src)
            WR_ZERO: l_wdata = '0;
            WR_LKK:  l_wdata = lkk_new;
            WR_DIV:  l_wdata = dv_result;
            default: l_wdata = '0;
        endcase

        stat.q_pos     = !q_sat[31] && (q_sat != 32'sd0);
        stat.sqrt_busy = sq_busy_reg;
        stat.div_busy  = dv_busy_reg;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.acc_load)
            acc_reg <= 52'(signed'(a_rdata));
        else if (cmd.acc_sub)
            acc_reg <= acc_reg - 52'(prod_rnd);
        if (cmd.mul_en)
            prod_reg <= signed'(l_rdata0) * signed'(l_rdata1);
        if (cmd.l_we && cmd.wr_src == WR_LKK)
            lkk_reg <= lkk_new[24:0];
        if (cmd.out_load)
        begin
            l_value       <= cmd.out_upper ? 32'sd0 : signed'(l_rdata0);
            column_failed <= fail_reg[cmd.out_col];
            last_of_tile  <= cmd.out_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_busy_reg <= 1'b0;
            dv_busy_reg <= 1'b0;
            fail_reg    <= '0;
            sq_cnt_reg  <= '0;
            dv_cnt_reg  <= '0;
        end
        else
        begin
            if (cmd.fail_clear)
                fail_reg <= '0;
            else if (cmd.fail_set)
                fail_reg[cmd.fail_idx] <= 1'b1;

            // Two radicand bits per step, one root bit out.
            if (cmd.sqrt_start)
            begin
                sq_x_reg    <= {q_sat, 16'd0};
                sq_rem_reg  <= '0;
                sq_root_reg <= '0;
                sq_cnt_reg  <= 5'd23;
                sq_busy_reg <= 1'b1;
            end
            else if (sq_busy_reg)
            begin
                sq_x_reg <= {sq_x_reg[45:0], 2'b00};
                if (sq_rem_sh >= sq_trial)
                begin
                    sq_rem_reg  <= sq_rem_sh - sq_trial;
                    sq_root_reg <= {sq_root_reg[22:0], 1'b1};
                end
                else
                begin
                    sq_rem_reg  <= sq_rem_sh;
                    sq_root_reg <= {sq_root_reg[22:0], 1'b0};
                end
                sq_cnt_reg <= sq_cnt_reg - 5'd1;
                if (sq_cnt_reg == 5'd0)
                    sq_busy_reg <= 1'b0;
            end

            // Restoring divide, one quotient bit per step; half divisor added for rounding.
            if (cmd.div_start)
            begin
                dv_n_reg    <= {dv_mag, 16'd0} + {24'd0, lkk_reg[24:1]};
                dv_neg_reg  <= q_sat[31];
                dv_rem_reg  <= '0;
                dv_q_reg    <= '0;
                dv_cnt_reg  <= 6'd47;
                dv_busy_reg <= 1'b1;
            end
            else if (dv_busy_reg)
            begin
                dv_n_reg <= {dv_n_reg[46:0], 1'b0};
                if (dv_rem_sh >= {1'b0, lkk_reg})
                begin
                    dv_rem_reg <= dv_rem_sh - {1'b0, lkk_reg};
                    dv_q_reg   <= {dv_q_reg[46:0], 1'b1};
                end
                else
                begin
                    dv_rem_reg <= dv_rem_sh;
                    dv_q_reg   <= {dv_q_reg[46:0], 1'b0};
                end
                dv_cnt_reg <= dv_cnt_reg - 6'd1;
                if (dv_cnt_reg == 6'd0)
                    dv_busy_reg <= 1'b0;
            end
        end
    end
endmodule
`default_nettype wire

// File: rtl/chol_ctrl.sv
// Controller: load counters, size register and the sequencer for factor and unload.
// Depends on chol_pkg.
`default_nettype none
module chol_ctrl (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_write,
    input  wire logic [chol_pkg::SIZE_W-1:0]   cfg_data,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output chol_pkg::cmd_t                     cmd,
    input  wire chol_pkg::stat_t               stat
);
    import chol_pkg::*;

    typedef enum logic [3:0] {
        S_LOAD,
        S_ELEM_RDA,
        S_ELEM_ACC,
        S_MAC_RD,
        S_MAC_MUL,
        S_MAC_SUB,
        S_DECIDE,
        S_SQRT,
        S_DIV,
        S_FILL_ZERO,
        S_NEXT,
        S_OUT_RD,
        S_OUT_LD,
        S_OUT_SEND
    } state_t;

    state_t             state_reg;
    logic [SIZE_W-1:0]  size_reg;
    logic [IDX_W-1:0]   i_reg, j_reg, k_reg;
    logic [IDX_W-1:0]   nm1;
    logic               in_acc;

    always_comb
    begin
        if (size_reg == '0)
            nm1 = '0;
        else if (size_reg > SIZE_W'(TILE_MAX))
            nm1 = IDX_W'(TILE_MAX - 1);
        else
            nm1 = IDX_W'(size_reg - 1'b1);

        in_stall  = (state_reg != S_LOAD);
        out_valid = (state_reg == S_OUT_SEND);
        in_acc    = in_valid && !in_stall;

        cmd            = '0;
        cmd.wr_src     = WR_ZERO;
        cmd.a_we       = in_acc;
        cmd.a_waddr    = {i_reg, j_reg};
        cmd.a_raddr    = {i_reg, k_reg};
        cmd.l_raddr0   = {i_reg, j_reg};
        cmd.l_raddr1   = {k_reg, j_reg};
        cmd.l_waddr    = {i_reg, k_reg};
        cmd.fail_idx   = k_reg;
        cmd.out_col    = j_reg;
        cmd.out_upper  = (j_reg > i_reg);
        cmd.out_last   = (i_reg == nm1) && (j_reg == nm1);
        case (state_reg)
            S_LOAD:      cmd.fail_clear = in_acc && (i_reg == nm1) && (j_reg == nm1);
            S_ELEM_ACC:  cmd.acc_load = 1'b1;
            S_MAC_MUL:   cmd.mul_en = 1'b1;
            S_MAC_SUB:   cmd.acc_sub = 1'b1;
            S_DECIDE:
            begin
                cmd.sqrt_start = (i_reg == k_reg) && stat.q_pos;
                cmd.fail_set   = (i_reg == k_reg) && !stat.q_pos;
                cmd.div_start  = (i_reg != k_reg);
            end
            S_SQRT:
            begin
                cmd.l_we   = !stat.sqrt_busy;
                cmd.wr_src = WR_LKK;
            end
            S_DIV:
            begin
                cmd.l_we   = !stat.div_busy;
                cmd.wr_src = WR_DIV;
            end
            S_FILL_ZERO: cmd.l_we = 1'b1;
            S_OUT_LD:    cmd.out_load = 1'b1;
            default:     ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
            size_reg  <= SIZE_W'(TILE_MAX);
            i_reg     <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
        end
        else
        begin
            case (state_reg)
                S_LOAD:
                begin
                    if (cfg_write)
                    begin
                        size_reg <= cfg_data;
                        i_reg    <= '0;
                        j_reg    <= '0;
                    end
                    else if (in_acc)
                    begin
                        if (j_reg == nm1)
                        begin
                            j_reg <= '0;
                            if (i_reg == nm1)
                            begin
                                i_reg     <= '0;
                                k_reg     <= '0;
                                state_reg <= S_ELEM_RDA;
                            end
                            else
                                i_reg <= i_reg + 1'b1;
                        end
                        else
                            j_reg <= j_reg + 1'b1;
                    end
                end
                S_ELEM_RDA: state_reg <= S_ELEM_ACC;
                S_ELEM_ACC:
                begin
                    j_reg     <= '0;
                    state_reg <= (k_reg == '0) ? S_DECIDE : S_MAC_RD;
                end
                S_MAC_RD:  state_reg <= S_MAC_MUL;
                S_MAC_MUL: state_reg <= S_MAC_SUB;
                S_MAC_SUB:
                begin
                    if (j_reg == k_reg - 1'b1)
                        state_reg <= S_DECIDE;
                    else
                    begin
                        j_reg     <= j_reg + 1'b1;
                        state_reg <= S_MAC_RD;
                    end
                end
                S_DECIDE:
                begin
                    if (i_reg != k_reg)
                        state_reg <= S_DIV;
                    else if (stat.q_pos)
                        state_reg <= S_SQRT;
                    else
                        state_reg <= S_FILL_ZERO;
                end
                S_SQRT:
                begin
                    if (!stat.sqrt_busy)
                        state_reg <= S_NEXT;
                end
                S_DIV:
                begin
                    if (!stat.div_busy)
                        state_reg <= S_NEXT;
                end
                // Zero the rest of a failed column, then move to the next column.
                S_FILL_ZERO:
                begin
                    if (i_reg == nm1)
                        state_reg <= S_NEXT;
                    else
                        i_reg <= i_reg + 1'b1;
                end
                S_NEXT:
                begin
                    if (i_reg == nm1)
                    begin
                        if (k_reg == nm1)
                        begin
                            i_reg     <= '0;
                            j_reg     <= '0;
                            state_reg <= S_OUT_RD;
                        end
                        else
                        begin
                            k_reg     <= k_reg + 1'b1;
                            i_reg     <= k_reg + 1'b1;
                            state_reg <= S_ELEM_RDA;
                        end
                    end
                    else
                    begin
                        i_reg     <= i_reg + 1'b1;
                        state_reg <= S_ELEM_RDA;
                    end
                end
                S_OUT_RD: state_reg <= S_OUT_LD;
                S_OUT_LD: state_reg <= S_OUT_SEND;
                S_OUT_SEND:
                begin
                    if (!out_stall)
                    begin
                        if (j_reg == nm1)
                        begin
                            j_reg <= '0;
                            if (i_reg == nm1)
                            begin
                                i_reg     <= '0;
                                state_reg <= S_LOAD;
                            end
                            else
                            begin
                                i_reg     <= i_reg + 1'b1;
                                state_reg <= S_OUT_RD;
                            end
                        end
                        else
                        begin
                            j_reg     <= j_reg + 1'b1;
                            state_reg <= S_OUT_RD;
                        end
                    end
                end
                default: state_reg <= S_LOAD;
            endcase
        end
    end

    a_no_load_during_unload: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("request taken while a result is pending");
    a_sqrt_runs: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.sqrt_start |=> stat.sqrt_busy)
        else $error("square root did not start");
    a_idle_units: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LOAD) |-> (!stat.sqrt_busy && !stat.div_busy))
        else $error("arithmetic unit busy while loading");
    a_write_in_column: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.l_we |-> (i_reg >= k_reg))
        else $error("factor write above the diagonal");
endmodule
`default_nettype wire

// File: rtl/cholesky_tile_factor.sv
// Cholesky tile factor: collects an N x N symmetric tile (N = size setting, 1..8,
// 0 acts as 1, above 8 as 8) in row-major order, then factors it in Q16.16 and
// returns the N*N lower-triangular factor elements in row-major order, with zeros
// above the diagonal and column_failed set for columns whose pivot was not positive
// (such columns read as zero). Input requests are taken one per cycle while loading;
// after the last one the block stalls its input until the last result is taken.
// Each factor element reads its tile entry, then runs each inner-product term through
// read, multiply and subtract states on the shared multiplier, then a diagonal square
// root or an off-diagonal bit-serial divide; a failed pivot instead zeroes its column
// at one cycle per entry. Each result is unloaded through read, load and send states.
// Writing the size setting abandons a partly loaded tile.
// Depends on chol_pkg, chol_ctrl and chol_dp.
`default_nettype none
module cholesky_tile_factor (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_write,
    input  wire logic [chol_pkg::SIZE_W-1:0]   cfg_data,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic signed [31:0]            a_value,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic signed [31:0]                 l_value,
    output logic                               column_failed,
    output logic                               last_of_tile
);
    import chol_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    chol_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .cfg_write(cfg_write), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall), .out_valid(out_valid),
        .out_stall(out_stall), .cmd(cmd), .stat(stat)
    );

    chol_dp u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat), .a_value(a_value),
        .l_value(l_value), .column_failed(column_failed), .last_of_tile(last_of_tile)
    );
endmodule
`default_nettype wire

// File: verif/cholesky_checker.sv
// Checker for the Cholesky tile factor: watches the size register and both
// channels, predicts each factor tile in Q16.16 and compares every result.
// Depends on chol_pkg only for widths and tile sizes.
`timescale 1ns / 1ps
`default_nettype none
module cholesky_checker (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_write,
    input  wire logic [chol_pkg::SIZE_W-1:0] cfg_data,
    input  wire logic                        in_valid,
    input  wire logic                        in_stall,
    input  wire logic signed [31:0]          a_value,
    input  wire logic                        out_valid,
    input  wire logic                        out_stall,
    input  wire logic signed [31:0]          l_value,
    input  wire logic                        column_failed,
    input  wire logic                        last_of_tile,
    output int                               fail_count,
    output int                               pending
);
    import chol_pkg::*;

    typedef struct packed {
        logic signed [31:0] l_value;
        logic               column_failed;
        logic               last_of_tile;
    } factor_elem_t;

    factor_elem_t       factor_q[$];
    logic [3:0]         edge_reg;
    logic signed [31:0] tile_in [DEPTH];
    logic signed [31:0] tile_l [DEPTH];
    logic               col_bad [TILE_MAX];
    int                 loaded;

    assign pending = factor_q.size();

    function automatic int tile_edge(logic [3:0] s);
        if (s == 0) return 1;
        if (s > TILE_MAX) return TILE_MAX;
        return int'(s);
    endfunction

    // Q16.16 product, rounded to nearest with ties toward +inf.
    function automatic longint qmul(logic signed [31:0] a, logic signed [31:0] b);
        longint p;
        p = longint'(a) * longint'(b);
        return (p + 64'sh8000) >>> 16;
    endfunction

    function automatic logic signed [31:0] sat(longint v);
        if (v > 64'sd2147483647) return 32'sh7fffffff;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic longint root_near(longint x);
        longint r;
        r = 0;
        while ((r + 1) * (r + 1) <= x) r = r + 1 + ((x - (r + 1) * (r + 1)) >> 40);
        while (r * r > x) r--;
        if (x - r * r > r) r++;
        return r;
    endfunction

    function automatic logic signed [31:0] qdiv(logic signed [31:0] num, longint den);
        longint mag, quo;
        mag = (num < 0) ? -longint'(num) : longint'(num);
        quo = (mag * 65536 + den / 2) / den;
        return sat((num < 0) ? -quo : quo);
    endfunction

    task automatic factor_tile(int n);
        longint acc;
        logic signed [31:0] q, lkk;
        factor_elem_t e;
        for (int i = 0; i < DEPTH; i++) tile_l[i] = '0;
        for (int i = 0; i < TILE_MAX; i++) col_bad[i] = 1'b0;
        for (int k = 0; k < n; k++)
        begin
            acc = tile_in[k * n + k];
            for (int j = 0; j < k; j++) acc -= qmul(tile_l[k * n + j], tile_l[k * n + j]);
            q = sat(acc);
            if (q <= 0)
            begin
                col_bad[k] = 1'b1;
                continue;
            end
            lkk = 32'(root_near(longint'(q) <<< 16));
            tile_l[k * n + k] = lkk;
            for (int i = k + 1; i < n; i++)
            begin
                acc = tile_in[i * n + k];
                for (int j = 0; j < k; j++)
                    acc -= qmul(tile_l[i * n + j], tile_l[k * n + j]);
                tile_l[i * n + k] = qdiv(sat(acc), longint'(lkk));
            end
        end
        for (int i = 0; i < n; i++)
            for (int j = 0; j < n; j++)
            begin
                e.l_value       = (j <= i) ? tile_l[i * n + j] : '0;
                e.column_failed = col_bad[j];
                e.last_of_tile  = (i == n - 1) && (j == n - 1);
                factor_q.push_back(e);
            end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        factor_elem_t exp_e;
        int n;
        int errs;
        errs = 0;
        if (!rst_n)
        begin
            edge_reg   <= 4'd8;
            loaded     = 0;
            fail_count <= 0;
        end
        else
        begin
            if (cfg_write)
            begin
                edge_reg <= cfg_data;
                loaded = 0;
            end
            else if (in_valid && !in_stall)
            begin
                n = tile_edge(edge_reg);
                tile_in[loaded] = a_value;
                loaded++;
                if (loaded == n * n)
                begin
                    loaded = 0;
                    factor_tile(n);
                end
            end
            if (out_valid && !out_stall)
            begin
                if (factor_q.size() == 0)
                begin
                    $error("result with nothing expected: l_value %h", l_value);
                    errs++;
                end
                else
                begin
                    exp_e = factor_q.pop_front();
                    if (l_value !== exp_e.l_value)
                    begin
                        $error("l_value expected %h actual %h", exp_e.l_value, l_value);
                        errs++;
                    end
                    if (column_failed !== exp_e.column_failed)
                    begin
                        $error("column_failed expected %b actual %b",
                               exp_e.column_failed, column_failed);
                        errs++;
                    end
                    if (last_of_tile !== exp_e.last_of_tile)
                    begin
                        $error("last_of_tile expected %b actual %b",
                               exp_e.last_of_tile, last_of_tile);
                        errs++;
                    end
                end
            end
            if (errs != 0)
                fail_count <= fail_count + errs;
        end
    end
endmodule
`default_nettype wire

// File: verif/tb_cholesky_tile_factor.sv
// Testbench top for cholesky_tile_factor: drives size settings and tiles of
// directed and random Q16.16 data; cholesky_checker predicts and compares.
`timescale 1ns / 1ps
`default_nettype none
module tb_cholesky_tile_factor;
    import chol_pkg::*;

    localparam int IDLE_LIMIT = 20000;

    logic               clk;
    logic               rst_n;
    logic               cfg_write;
    logic [SIZE_W-1:0]  cfg_data;
    logic               in_valid;
    logic               in_stall;
    logic signed [31:0] a_value;
    logic               out_valid;
    logic               out_stall;
    logic signed [31:0] l_value;
    logic               column_failed;
    logic               last_of_tile;
    int                 fail_count;
    int                 pending;
    int                 idle_cycles;
    bit                 hold_off;
    bit                 stim_done;

    cholesky_tile_factor u_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_write(cfg_write), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall), .a_value(a_value),
        .out_valid(out_valid), .out_stall(out_stall), .l_value(l_value),
        .column_failed(column_failed), .last_of_tile(last_of_tile)
    );

    cholesky_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .cfg_write(cfg_write), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall), .a_value(a_value),
        .out_valid(out_valid), .out_stall(out_stall), .l_value(l_value),
        .column_failed(column_failed), .last_of_tile(last_of_tile),
        .fail_count(fail_count), .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Receiver: random stall pattern, with one long hold-off on request.
    // The hold-off outlasts a full size-8 factorization so results back up.
    initial
    begin
        int mode;
        out_stall = 1'b0;
        mode = 0;
        forever
        begin
            @(posedge clk);
            if (hold_off)
            begin
                out_stall <= 1'b1;
                repeat (4000) @(posedge clk);
                hold_off = 1'b0;
            end
            if ($urandom_range(0, 63) == 0) mode = $urandom_range(0, 2);
            case (mode)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 3) == 0);
                default: out_stall <= ($urandom_range(0, 1) == 0);
            endcase
        end
    end

    // Watchdog: count cycles with no accepted request on either side and no size write.
    initial
    begin
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    int burst_left;

    task automatic send_elem(logic signed [31:0] v);
        if (burst_left == 0)
        begin
            repeat ($urandom_range(0, 6)) @(posedge clk);
            burst_left = $urandom_range(1, 20);
        end
        in_valid <= 1'b1;
        a_value  <= v;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        burst_left--;
        if (burst_left == 0) in_valid <= 1'b0;
    endtask

    task automatic set_size(logic [SIZE_W-1:0] s);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (100) @(posedge clk);
        cfg_write <= 1'b1;
        cfg_data  <= s;
        @(posedge clk);
        cfg_write <= 1'b0;
        burst_left = 0;
    endtask

    function automatic logic signed [31:0] rand_val(int kind);
        case (kind)
            0: return $urandom;
            1: return $signed($urandom_range(0, 32'h0003_ffff)) - 32'sh0001_ffff;
            default: return $signed($urandom_range(0, 32'h0000_ffff)) - 32'sh0000_7fff;
        endcase
    endfunction

    // Positive-definite tile: small symmetric off-diagonals, large diagonal.
    task automatic send_spd_tile(int n);
        logic signed [31:0] m [8][8];
        for (int i = 0; i < n; i++)
            for (int j = 0; j <= i; j++)
            begin
                m[i][j] = (i == j) ? $signed($urandom_range(32'h0001_0000, 32'h0040_0000))
                                   : rand_val(2);
                m[j][i] = m[i][j];
            end
        for (int i = 0; i < n; i++)
            for (int j = 0; j < n; j++) send_elem(m[i][j]);
    endtask

    int sent;
    int n_cur;

    initial
    begin
        rst_n     = 1'b0;
        cfg_write = 1'b0;
        cfg_data  = '0;
        in_valid  = 1'b0;
        a_value   = '0;
        hold_off  = 1'b0;
        stim_done = 1'b0;
        burst_left = 0;
        sent = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: default size 8 with a well-formed tile, then extremes.
        send_spd_tile(8);
        set_size(4'd1);
        send_elem(32'sh7fffffff);
        send_elem(32'sh80000000);
        send_elem(32'sh0000_0000);
        send_elem(32'sh0000_0001);
        set_size(4'd0);
        send_elem(32'sh0001_0000);
        set_size(4'd2);
        // failed first column, then saturating divide
        send_elem(-32'sh0001_0000); send_elem(32'sh7fffffff);
        send_elem(32'sh7fffffff);   send_elem(32'sh0004_0000);
        send_elem(32'sh0000_0001); send_elem(32'sh80000000);
        send_elem(32'sh80000000);  send_elem(32'sh7fffffff);
        // abandon a partial tile by writing the size mid-tile
        set_size(4'd3);
        send_elem(32'sh1234_5678); send_elem(32'sh0000_ffff);
        set_size(4'd15);
        hold_off = 1'b1;
        send_spd_tile(8);
        send_spd_tile(8);
        sent = 207;

        while (sent < 410)
        begin
            set_size(4'($urandom_range(0, 15)));
            n_cur = (cfg_data == 0) ? 1 : (cfg_data > 8 ? 8 : cfg_data);
            repeat ($urandom_range(1, 3))
            begin
                if (sent < 410)
                begin
                    if ($urandom_range(0, 3) != 0) send_spd_tile(n_cur);
                    else
                        for (int i = 0; i < n_cur * n_cur; i++)
                            send_elem(rand_val($urandom_range(0, 2)));
                    sent += n_cur * n_cur;
                end
            end
        end
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (200) @(posedge clk);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
`default_nettype wire

// File: files.f
rtl/chol_pkg.sv
rtl/chol_ram.sv
rtl/chol_dp.sv
rtl/chol_ctrl.sv
rtl/cholesky_tile_factor.sv
verif/cholesky_checker.sv
verif/tb_cholesky_tile_factor.sv
